@@ design/sird_pkg.sv @@
package sird_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int RADIX_W = 5;
  localparam int SYM_W = 8;
  localparam int SYM_IDX_W = 4;
  localparam int TBL_W = 128;
  localparam int RECIP_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_HIGH = 2'd2;

  localparam logic [SYM_W-1:0] SYM_PLUS = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_FIX,
    ST_SIGN,
    ST_EMIT
  } state_t;

  function automatic logic [SYM_W-1:0] symbol_of(input logic [TBL_W-1:0] tbl,
                                                 input logic [SYM_IDX_W-1:0] d);
    return tbl[{d, 3'b000} +: SYM_W];
  endfunction

  // floor(2^32 / r)
  function automatic logic [RECIP_W-1:0] recip32(input logic [RADIX_W-1:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      5'd2:    m = 32'h8000_0000;
      5'd3:    m = 32'h5555_5555;
      5'd4:    m = 32'h4000_0000;
      5'd5:    m = 32'h3333_3333;
      5'd6:    m = 32'h2AAA_AAAA;
      5'd7:    m = 32'h2492_4924;
      5'd8:    m = 32'h2000_0000;
      5'd9:    m = 32'h1C71_C71C;
      5'd10:   m = 32'h1999_9999;
      5'd11:   m = 32'h1745_D174;
      5'd12:   m = 32'h1555_5555;
      5'd13:   m = 32'h13B1_3B13;
      5'd14:   m = 32'h1249_2492;
      5'd15:   m = 32'h1111_1111;
      5'd16:   m = 32'h1000_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ design/signed_integer_to_radix_digits.sv @@
// The base check steps through the symbols below the radix, each digit then passes
// through a multiply and a fix state on the shared reciprocal divider, and one symbol
// leaves per cycle while the output is not stalled (after a minus sign if negative).
// A new value is taken only after the last symbol of the previous one is loaded.
// Reset: synchronous; clears the configuration to zero (an invalid base) and
// empties the output register.
module signed_integer_to_radix_digits import sird_pkg::*; #(
  parameter int MAX_BASE = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [SYM_W-1:0]              symbol,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int DW = $clog2(MAX_BASE);
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  state_t state;
  state_t state_next;

  logic [RADIX_W-1:0]     radix;
  logic [CFG_DATA_W-1:0]  symbols_low;
  logic [CFG_DATA_W-1:0]  symbols_high;
  logic [TBL_W-1:0]       tbl;

  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] value_u;
  logic                   neg;
  logic [DW-1:0]          idx;
  logic [DW-1:0]          stack [VALUE_WIDTH];
  logic [CW-1:0]          count;

  logic                   chk_bad;
  logic                   div_go;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_q;
  logic [DW-1:0]          div_rem;

  logic                   push;
  logic                   pop;
  logic                   slot_free;
  logic                   out_load;
  logic [SYM_W-1:0]       symbol_next;
  logic                   last_next;

  assign tbl = {symbols_high, symbols_low};
  assign value_u = $unsigned(value);
  assign in_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || !out_stall;

  sird_base_check #(
    .MAX_BASE(MAX_BASE),
    .IDX_W(DW)
  ) u_check (
    .idx(idx),
    .radix(radix),
    .tbl(tbl),
    .bad(chk_bad)
  );

  sird_divider #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .DIGIT_WIDTH(DW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .go(div_go),
    .dividend(mag),
    .radix(radix),
    .done(div_done),
    .quotient(div_q),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= '0;
      symbols_low <= '0;
      symbols_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIX:    radix <= cfg_data[RADIX_W-1:0];
        REG_SYM_LOW:  symbols_low <= cfg_data;
        REG_SYM_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_go = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    out_load = 1'b0;
    symbol_next = '0;
    last_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_bad) begin
          state_next = ST_IDLE;
        end else if (RADIX_W'(idx) + RADIX_W'(1) == radix) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        div_go = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        push = 1'b1;
        if (div_q == '0 || count == CW'(VALUE_WIDTH - 1)) begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_load = 1'b1;
          symbol_next = SYM_MINUS;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          pop = 1'b1;
          symbol_next = symbol_of(tbl, SYM_IDX_W'(stack[0]));
          last_next = (count == CW'(1));
          if (count == CW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      mag <= value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;
      neg <= value_u[VALUE_WIDTH-1];
      idx <= '0;
      count <= '0;
    end else begin
      if (state == ST_CHECK) begin
        idx <= idx + DW'(1);
      end
      if (push) begin
        mag <= div_q;
        count <= count + CW'(1);
      end else if (pop) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack[0] <= div_rem;
      for (int k = 1; k < VALUE_WIDTH; k++) begin
        stack[k] <= stack[k-1];
      end
    end else if (pop) begin
      for (int k = 0; k < VALUE_WIDTH - 1; k++) begin
        stack[k] <= stack[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      symbol <= symbol_next;
      last <= last_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_CHECK) |-> count <= CW'(VALUE_WIDTH))
    else $error("digit stack overflow");

  a_fix_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIX |-> div_done)
    else $error("divider result not ready");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIX |-> RADIX_W'(div_rem) < radix)
    else $error("remainder not below radix");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_load && last_next) |=> (state == ST_IDLE && out_valid && last))
    else $error("final symbol did not end the transaction");

endmodule

@@ design/sird_base_check.sv @@
module sird_base_check import sird_pkg::*; #(
  parameter int MAX_BASE = 16,
  parameter int IDX_W = 4
) (
  input  logic [IDX_W-1:0]   idx,
  input  logic [RADIX_W-1:0] radix,
  input  logic [TBL_W-1:0]   tbl,
  output logic               bad
);

  logic [SYM_W-1:0] sym;

  always_comb begin
    sym = symbol_of(tbl, SYM_IDX_W'(idx));
    bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_BASE)) ||
          (sym == '0) || (sym == SYM_PLUS) || (sym == SYM_MINUS);
    for (int j = 0; j < MAX_BASE; j++) begin
      if ((RADIX_W'(j) > RADIX_W'(idx)) && (RADIX_W'(j) < radix) &&
          (symbol_of(tbl, SYM_IDX_W'(j)) == sym)) begin
        bad = 1'b1;
      end
    end
  end

endmodule

@@ design/sird_divider.sv @@
module sird_divider import sird_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int DIGIT_WIDTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     radix,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [DIGIT_WIDTH-1:0] remainder
);

  localparam int PW = 2 * VALUE_WIDTH;

  logic [RECIP_W-1:0]     m32;
  logic [VALUE_WIDTH-1:0] m;
  logic [PW-1:0]          prod;
  logic [VALUE_WIDTH-1:0] dend;
  logic [RADIX_W-1:0]     r;
  logic [VALUE_WIDTH-1:0] q_est;
  logic [VALUE_WIDTH-1:0] back;
  logic [VALUE_WIDTH-1:0] rem0;
  logic [VALUE_WIDTH-1:0] rem1;

  assign m32 = recip32(radix);
  assign m = m32[RECIP_W-1 -: VALUE_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      prod <= PW'(dividend) * PW'(m);
      dend <= dividend;
      r <= radix;
    end
  end

  always_comb begin
    q_est = prod[PW-1:VALUE_WIDTH];
    back = VALUE_WIDTH'(q_est * VALUE_WIDTH'(r));
    rem0 = dend - back;
    rem1 = rem0 - VALUE_WIDTH'(r);
    if (rem0 >= VALUE_WIDTH'(r)) begin
      quotient = q_est + VALUE_WIDTH'(1);
      remainder = rem1[DIGIT_WIDTH-1:0];
    end else begin
      quotient = q_est;
      remainder = rem0[DIGIT_WIDTH-1:0];
    end
  end

endmodule

@@ tb/sv/tb_signed_integer_to_radix_digits.sv @@
module tb_signed_integer_to_radix_digits;
  import sird_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int HOLD_OFF = 150;
  localparam int WATCHDOG = 3000;
  localparam int PHASE_ITEMS = 28;
  localparam int SCRIPT_ROWS = 43;

  typedef enum logic {ROW_VALUE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } glyph_t;

  typedef struct {
    bit    typed;
    string text;
  } item_plan_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [31:0]           val;
    bit                    typed;
    string                 text;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [31:0]           value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SYM_W-1:0]      symbol;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int gap_pct = 18;
  int stall_pct = 83;
  int errors = 0;
  int stagnant = 0;

  logic [RADIX_W-1:0] cfg_radix = '0;
  logic [TBL_W-1:0]   cfg_glyphs = '0;

  glyph_t     glyphs_due[$];
  item_plan_t item_plans[$];

  row_t script [SCRIPT_ROWS] = '{
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd5,          1'b1, ""},
    '{ROW_WRITE, REG_SPARE,    64'hFFFF_FFFF_FFFF_FFFF, 32'd0,         1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd7,          1'b1, ""},
    '{ROW_WRITE, REG_RADIX,    64'hFFFF_FFFF_FFFF_FFEA, 32'd0,         1'b0, ""},
    '{ROW_WRITE, REG_SYM_LOW,  64'h3736_3534_3332_3130, 32'd0,         1'b0, ""},
    '{ROW_WRITE, REG_SYM_HIGH, 64'h0000_0000_0000_3938, 32'd0,         1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd0,          1'b1, "0"},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'hFFFF_FFFF,  1'b1, "-1"},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'h7FFF_FFFF,  1'b1, "2147483647"},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'h8000_0000,  1'b1, "-2147483648"},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd10,         1'b1, "10"},
    '{ROW_WRITE, REG_SYM_HIGH, 64'h4645_4443_4241_3938, 32'd0,         1'b0, ""},
    '{ROW_WRITE, REG_RADIX,    64'd16,                 32'd0,          1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'h8000_0000,  1'b1, "-80000000"},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'h7FFF_FFFF,  1'b1, "7FFFFFFF"},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'hDEAD_BEEF,  1'b1, "-21524111"},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd255,        1'b1, "FF"},
    '{ROW_WRITE, REG_RADIX,    64'd2,                  32'd0,          1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'h8000_0000,  1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'h7FFF_FFFF,  1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'hFFFF_FFFE,  1'b1, "-10"},
    '{ROW_WRITE, REG_RADIX,    64'd17,                 32'd0,          1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd3,          1'b1, ""},
    '{ROW_WRITE, REG_RADIX,    64'd1,                  32'd0,          1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd3,          1'b1, ""},
    '{ROW_WRITE, REG_RADIX,    64'd31,                 32'd0,          1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd3,          1'b1, ""},
    '{ROW_WRITE, REG_SYM_LOW,  64'h3736_3534_3330_3130, 32'd0,         1'b0, ""},
    '{ROW_WRITE, REG_RADIX,    64'd3,                  32'd0,          1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd4,          1'b1, ""},
    '{ROW_WRITE, REG_SYM_LOW,  64'h3736_3534_332B_3130, 32'd0,         1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd4,          1'b1, ""},
    '{ROW_WRITE, REG_SYM_LOW,  64'h3736_3534_3332_312D, 32'd0,         1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'hFFFF_FFFC,  1'b1, ""},
    '{ROW_WRITE, REG_SYM_LOW,  64'h3736_3534_3332_3130, 32'd0,         1'b0, ""},
    '{ROW_WRITE, REG_SYM_HIGH, 64'h4645_4443_4241_3900, 32'd0,         1'b0, ""},
    '{ROW_WRITE, REG_RADIX,    64'd9,                  32'd0,          1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd100,        1'b1, ""},
    '{ROW_WRITE, REG_RADIX,    64'd8,                  32'd0,          1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'd8,          1'b1, "10"},
    '{ROW_WRITE, REG_SYM_LOW,  64'h0000_0000_0001_80FF, 32'd0,         1'b0, ""},
    '{ROW_WRITE, REG_RADIX,    64'd3,                  32'd0,          1'b0, ""},
    '{ROW_VALUE, REG_RADIX,    64'd0,                  32'hFFFF_FFFB,  1'b0, ""}
  };

  signed_integer_to_radix_digits i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic [SYM_W-1:0] glyph_at(input int d);
    return cfg_glyphs[d*SYM_W +: SYM_W];
  endfunction

  function automatic bit base_usable();
    int n;
    logic [SYM_W-1:0] s;
    n = int'(cfg_radix);
    if (n < 2 || n > 16) return 1'b0;
    for (int i = 0; i < n; i++) begin
      s = glyph_at(i);
      if (s == 8'h00 || s == SYM_PLUS || s == SYM_MINUS) return 1'b0;
      for (int j = i + 1; j < n; j++) begin
        if (glyph_at(j) == s) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void spell_value(input logic [31:0] v);
    int unsigned mag;
    int unsigned r;
    int digs [32];
    int n;
    if (!base_usable()) return;
    r = 32'(cfg_radix);
    mag = v[31] ? (32'd0 - v) : v;
    n = 0;
    do begin
      digs[n] = mag % r;
      n++;
      mag = mag / r;
    end while (mag != 0);
    if (v[31]) glyphs_due.push_back('{SYM_MINUS, 1'b0});
    for (int k = n - 1; k >= 0; k--) begin
      glyphs_due.push_back('{glyph_at(digs[k]), k == 0});
    end
  endfunction

  always @(posedge clk) begin : monitor
    glyph_t want;
    item_plan_t job;
    if (rst) begin
      stagnant <= 0;
    end else begin
      if ((cfg_valid && cfg_ready) || (out_valid && !out_stall) || (in_valid && !in_stall)) begin
        stagnant <= 0;
      end else begin
        stagnant <= stagnant + 1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIX:    cfg_radix = cfg_data[RADIX_W-1:0];
          REG_SYM_LOW:  cfg_glyphs[63:0] = cfg_data;
          REG_SYM_HIGH: cfg_glyphs[127:64] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (glyphs_due.size() == 0) begin
          $display("%0t: unexpected symbol %02h last %b", $time, symbol, last);
          errors++;
        end else begin
          want = glyphs_due.pop_front();
          if (symbol !== want.sym) begin
            $display("%0t: symbol expected %02h got %02h", $time, want.sym, symbol);
            errors++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (item_plans.size() != 0) begin
          job = item_plans.pop_front();
        end else begin
          job = '{1'b0, ""};
        end
        if (job.typed) begin
          for (int i = 0; i < job.text.len(); i++) begin
            glyphs_due.push_back('{job.text[i], i == job.text.len() - 1});
          end
        end else begin
          spell_value(value);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [31:0] v, input bit typed, input string text);
    item_plans.push_back('{typed, text});
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (glyphs_due.size() != 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  initial begin
    watch_loop : while (stagnant < WATCHDOG) @(posedge clk);
    $display("tb_signed_integer_to_radix_digits NOT OK");
    $finish;
  end

  initial begin
    int made;
    int n;
    int r;
    int p;
    bit usable;
    bit quiet;
    bit taken [256];
    logic [SYM_W-1:0] s;
    logic [SYM_W-1:0] syms [16];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] rdata;
    logic [31:0] v;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    quiet = 1'b1;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (!quiet) begin
          settle();
          quiet = 1'b1;
        end
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_item(script[i].val, script[i].typed, script[i].text);
        quiet = 1'b0;
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          gap_pct = 18;
          stall_pct = 83;
        end
        1: begin
          gap_pct = 83;
          stall_pct = 18;
        end
        default: begin
          gap_pct = 0;
          stall_pct = 0;
        end
      endcase
      made = 0;
      while (made < PHASE_ITEMS) begin
        settle();
        for (int i = 0; i < 256; i++) taken[i] = 1'b0;
        for (int i = 0; i < 16; i++) begin
          do s = SYM_W'($urandom_range(1, 255)); while (taken[s] || s == SYM_PLUS || s == SYM_MINUS);
          taken[s] = 1'b1;
          syms[i] = s;
        end
        r = $urandom_range(2, 16);
        usable = 1'b1;
        case ($urandom_range(0, 5))
          0: begin
            r = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
            usable = 1'b0;
          end
          1: begin
            p = $urandom_range(0, r - 1);
            usable = 1'b0;
            case ($urandom_range(0, 3))
              0: syms[p] = 8'h00;
              1: syms[p] = SYM_PLUS;
              2: syms[p] = SYM_MINUS;
              default: syms[p] = syms[(p + 1) % r];
            endcase
          end
          default: ;
        endcase
        for (int i = 0; i < 8; i++) begin
          lo[8*i +: 8] = syms[i];
          hi[8*i +: 8] = syms[i+8];
        end
        rdata = {$urandom, $urandom};
        rdata[RADIX_W-1:0] = r[RADIX_W-1:0];
        write_reg(REG_SYM_LOW, lo);
        write_reg(REG_SYM_HIGH, hi);
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
        write_reg(REG_RADIX, rdata);
        n = $urandom_range(6, 14);
        repeat (n) begin
          case ($urandom_range(0, 4))
            1: v = $urandom_range(0, 40) - 20;
            2: begin
              case ($urandom_range(0, 3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
              endcase
            end
            3: begin
              v = $urandom >> $urandom_range(0, 31);
              if ($urandom_range(0, 1)) v = 32'd0 - v;
            end
            default: v = $urandom;
          endcase
          send_item(v, 1'b0, "");
          if (usable) made++;
        end
      end
    end

    settle();
    if (errors == 0 && glyphs_due.size() == 0) begin
      $display("tb_signed_integer_to_radix_digits OK");
    end else begin
      $display("tb_signed_integer_to_radix_digits NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sird_pkg.sv
design/sird_base_check.sv
design/sird_divider.sv
design/signed_integer_to_radix_digits.sv
tb/sv/tb_signed_integer_to_radix_digits.sv
